// ===== rtl/core/c2_coons_patch_point_eval_unit_macros.svh =====
// Assertion macros for the Coons patch point evaluator.
`ifndef C2_COONS_PATCH_POINT_EVAL_UNIT_MACROS_SVH
`define C2_COONS_PATCH_POINT_EVAL_UNIT_MACROS_SVH
`ifndef SYNTH
`define CPE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CPE_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPE_ASSERT(label, clk, rst, prop, msg)
`define CPE_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/cpe_pkg.sv =====
// Shared types and constants for the Coons patch point evaluator.
`default_nettype none
package cpe_pkg;
  localparam int MaxUKnots = 64;
  localparam int MaxVKnots = 64;
  localparam int MaxSpaceDim = 4;
  localparam int NBlend = 6;
  localparam int UcDepth = NBlend * MaxUKnots * MaxSpaceDim;
  localparam int VcDepth = NBlend * MaxVKnots * MaxSpaceDim;
  localparam int CnDepth = NBlend * NBlend * MaxSpaceDim;
  localparam int UbDepth = NBlend * MaxUKnots;
  localparam int VbDepth = NBlend * MaxVKnots;
  localparam int UcAw = $clog2(UcDepth);
  localparam int VcAw = $clog2(VcDepth);
  localparam int CnAw = $clog2(CnDepth);
  localparam int UbAw = $clog2(UbDepth);
  localparam int VbAw = $clog2(VbDepth);
  localparam int CmdQDepth = 4;
  localparam int CmdQAw = $clog2(CmdQDepth);

  typedef logic [CmdQAw-1:0] cmdq_ptr_t;
  typedef logic [CmdQAw:0] cmdq_count_t;

  localparam logic [2:0] ACT_LOAD_C = 3'd0;
  localparam logic [2:0] ACT_LOAD_D = 3'd1;
  localparam logic [2:0] ACT_LOAD_P = 3'd2;
  localparam logic [2:0] ACT_LOAD_HU = 3'd3;
  localparam logic [2:0] ACT_LOAD_HV = 3'd4;
  localparam logic [2:0] ACT_QUERY = 3'd5;

  localparam logic [1:0] REG_U_KNOTS = 2'd0;
  localparam logic [1:0] REG_V_KNOTS = 2'd1;
  localparam logic [1:0] REG_SPACE_DIM = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [10:0] load_index;
    logic signed [31:0] load_value;
    logic [5:0] u_pick;
    logic [5:0] v_pick;
    logic [1:0] coord_pick;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] coord_value;
    logic saturated;
    logic out_of_range;
  } out_item_t;

  // queued command: a load or a query, classified by the front end
  typedef struct packed {
    logic is_query;
    logic oor;
    logic [2:0] action;
    logic [10:0] load_index;
    logic signed [31:0] load_value;
    logic [5:0] u_pick;
    logic [5:0] v_pick;
    logic [1:0] coord_pick;
    logic [2:0] sd;
  } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/core/cpe_stream_if.sv =====
// Valid/ready channel interfaces for items and results.
`default_nettype none
interface cpe_in_if;
  logic valid;
  logic ready;
  cpe_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cpe_out_if;
  logic valid;
  logic ready;
  cpe_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/c2_coons_patch_point_eval_unit.sv =====
// Coons patch point evaluator top level.
// Usage: input channel "in" carries transactions with an action code; loads write
// one element of a table, queries return one coordinate on channel "out".
// Configuration: cfg_we/cfg_index/cfg_data write u_knot_count, v_knot_count,
// space_dim; write only while the block is idle.
// A four-entry command queue separates the front end from the evaluation
// sequencer, so loads and queries are taken while the back end is busy.
// Sequence: a load is written when the back end takes it from the queue; an
// out-of-range query registers its result when taken; a full query is computed
// on the single shared multiplier: 48 products of three steps each (address,
// operand, accumulate), a fetch of d for each knot term, the move from queue to
// sequencer and a final saturate.
// Throughput: one query at a time in the back end; loads drain one per cycle
// while the back end is idle and no result is pending.
// Reset clears registers to 1, 1, 3 and empties the queue; table contents are
// undefined until written.
// When out.ready is low the result holds and the back end waits; the queue
// fills and then in.ready drops.
`default_nettype none
`include "c2_coons_patch_point_eval_unit_macros.svh"
module c2_coons_patch_point_eval_unit (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [6:0] cfg_data,
  cpe_in_if.sink in,
  cpe_out_if.source out
);
  logic cmd_valid, cmd_ready;
  cpe_pkg::cmd_t cmd;

  cpe_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_action(in.data.action), .in_load_index(in.data.load_index),
    .in_load_value(in.data.load_value), .in_u_pick(in.data.u_pick),
    .in_v_pick(in.data.v_pick), .in_coord_pick(in.data.coord_pick),
    .in_valid(in.valid), .in_ready(in.ready),
    .cmd_valid, .cmd, .cmd_ready
  );

  cpe_back u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_ready,
    .out_valid(out.valid), .out_data(out.data), .out_ready(out.ready)
  );

  `CPE_ASSERT(a_out_hold, clk, rst, out.valid && !out.ready |=> out.valid, "result dropped")
  `CPE_ASSERT(a_oor_zero, clk, rst, out.valid && out.data.out_of_range |-> out.data.coord_value == 0 && !out.data.saturated, "bad out-of-range result")
  `CPE_ASSERT(a_no_take_busy, clk, rst, cmd_ready |-> !out.valid, "command taken with result pending")
endmodule
`default_nettype wire

// ===== rtl/core/cpe_front.sv =====
// Front end: config registers, item classification and command queue.
`default_nettype none
module cpe_front (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [6:0] cfg_data,
  input wire logic [2:0] in_action,
  input wire logic [10:0] in_load_index,
  input wire logic signed [31:0] in_load_value,
  input wire logic [5:0] in_u_pick,
  input wire logic [5:0] in_v_pick,
  input wire logic [1:0] in_coord_pick,
  input wire logic in_valid,
  output logic in_ready,
  output logic cmd_valid,
  output cpe_pkg::cmd_t cmd,
  input wire logic cmd_ready
);
  logic [6:0] u_knots;
  logic [6:0] v_knots;
  logic [2:0] space_dim;
  cpe_pkg::cmd_t q [cpe_pkg::CmdQDepth];
  cpe_pkg::cmdq_ptr_t wr_ptr;
  cpe_pkg::cmdq_ptr_t rd_ptr;
  cpe_pkg::cmdq_count_t count;
  logic [6:0] nu, nv;
  logic [2:0] sd;
  cpe_pkg::cmd_t c_in;
  logic push, pop;

  always_comb begin
    nu = (u_knots > 7'(cpe_pkg::MaxUKnots)) ? 7'(cpe_pkg::MaxUKnots) : u_knots;
    nv = (v_knots > 7'(cpe_pkg::MaxVKnots)) ? 7'(cpe_pkg::MaxVKnots) : v_knots;
    sd = (space_dim > 3'(cpe_pkg::MaxSpaceDim)) ? 3'(cpe_pkg::MaxSpaceDim) : space_dim;
    c_in.is_query = (in_action == cpe_pkg::ACT_QUERY);
    c_in.oor = ({1'b0, in_u_pick} >= nu) || ({1'b0, in_v_pick} >= nv)
               || ({1'b0, in_coord_pick} >= sd);
    c_in.action = in_action;
    c_in.load_index = in_load_index;
    c_in.load_value = in_load_value;
    c_in.u_pick = in_u_pick;
    c_in.v_pick = in_v_pick;
    c_in.coord_pick = in_coord_pick;
    c_in.sd = sd;
  end

  assign in_ready = (count != cpe_pkg::cmdq_count_t'(cpe_pkg::CmdQDepth));
  assign push = in_valid && in_ready;
  assign cmd_valid = (count != '0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      u_knots <= 7'd1;
      v_knots <= 7'd1;
      space_dim <= 3'd3;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cpe_pkg::REG_U_KNOTS: u_knots <= cfg_data;
          cpe_pkg::REG_V_KNOTS: v_knots <= cfg_data;
          cpe_pkg::REG_SPACE_DIM: space_dim <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (push) wr_ptr <= wr_ptr + cpe_pkg::cmdq_ptr_t'(1);
      if (pop) rd_ptr <= rd_ptr + cpe_pkg::cmdq_ptr_t'(1);
      count <= count + cpe_pkg::cmdq_count_t'(push) - cpe_pkg::cmdq_count_t'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= c_in;
  end
endmodule
`default_nettype wire

// ===== rtl/core/cpe_back.sv =====
// Back end: table memories and the shared multiply-accumulate sequencer.
`default_nettype none
module cpe_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_valid,
  input wire cpe_pkg::cmd_t cmd,
  output logic cmd_ready,
  output logic out_valid,
  output cpe_pkg::out_item_t out_data,
  input wire logic out_ready
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AINIT = 3'd1;
  localparam logic [2:0] S_AMUL = 3'd2;
  localparam logic [2:0] S_CMUL = 3'd3;
  localparam logic [2:0] S_UMUL = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic signed [31:0] uc_mem [cpe_pkg::UcDepth];
  logic signed [31:0] vc_mem [cpe_pkg::VcDepth];
  logic signed [31:0] cn_mem [cpe_pkg::CnDepth];
  logic signed [31:0] ub_mem [cpe_pkg::UbDepth];
  logic signed [31:0] vb_mem [cpe_pkg::VbDepth];

  logic [2:0] state;
  logic [2:0] k, m;
  logic [2:0] phase;
  cpe_pkg::cmd_t cur;
  logic signed [51:0] a_acc;
  logic signed [51:0] acc;
  logic signed [31:0] ak;
  logic clip;
  logic signed [31:0] opa, opb;
  logic signed [31:0] ra_uc, ra_vc, ra_cn, ra_ub, ra_vb, ra_vbm;
  logic signed [63:0] prod;
  logic signed [47:0] qprod;
  logic signed [31:0] a_sat;
  logic a_clip;
  logic signed [31:0] f_sat;
  logic f_clip;
  logic [10:0] uc_addr, vc_addr;
  logic [7:0] cn_addr;
  logic [8:0] ub_addr, vb_addr, vbm_addr;
  logic [8:0] ui6, vj6;

  assign ui6 = 9'(cur.u_pick) * 9'd6;
  assign vj6 = 9'(cur.v_pick) * 9'd6;
  assign uc_addr = 11'((ui6 + 9'(k)) * 11'(cur.sd) + 11'(cur.coord_pick));
  assign vc_addr = 11'((vj6 + 9'(k)) * 11'(cur.sd) + 11'(cur.coord_pick));
  assign cn_addr = 8'((8'(k) * 8'd6 + 8'(m)) * 8'(cur.sd) + 8'(cur.coord_pick));
  assign ub_addr = ui6 + 9'(k);
  assign vb_addr = vj6 + 9'(k);
  assign vbm_addr = vj6 + 9'(m);

  // write ports, driven by load commands
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready && !cmd.is_query) begin
      unique case (cmd.action)
        cpe_pkg::ACT_LOAD_C:
          if (cmd.load_index < 11'(cpe_pkg::UcDepth))
            uc_mem[cmd.load_index[cpe_pkg::UcAw-1:0]] <= cmd.load_value;
        cpe_pkg::ACT_LOAD_D:
          if (cmd.load_index < 11'(cpe_pkg::VcDepth))
            vc_mem[cmd.load_index[cpe_pkg::VcAw-1:0]] <= cmd.load_value;
        cpe_pkg::ACT_LOAD_P:
          if (cmd.load_index < 11'(cpe_pkg::CnDepth))
            cn_mem[cmd.load_index[cpe_pkg::CnAw-1:0]] <= cmd.load_value;
        cpe_pkg::ACT_LOAD_HU:
          if (cmd.load_index < 11'(cpe_pkg::UbDepth))
            ub_mem[cmd.load_index[cpe_pkg::UbAw-1:0]] <= cmd.load_value;
        cpe_pkg::ACT_LOAD_HV:
          if (cmd.load_index < 11'(cpe_pkg::VbDepth))
            vb_mem[cmd.load_index[cpe_pkg::VbAw-1:0]] <= cmd.load_value;
        default: ;
      endcase
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    ra_uc <= uc_mem[uc_addr];
    ra_vc <= vc_mem[vc_addr];
    ra_cn <= cn_mem[cn_addr];
    ra_ub <= ub_mem[ub_addr];
    ra_vb <= vb_mem[vb_addr];
    ra_vbm <= vb_mem[vbm_addr];
  end

  assign prod = 64'(opa) * 64'(opb);
  assign qprod = 48'((prod + 64'sd32768) >>> 16);

  always_comb begin
    if (a_acc > 52'sd2147483647) begin
      a_sat = 32'sh7fffffff; a_clip = 1'b1;
    end else if (a_acc < -52'sd2147483648) begin
      a_sat = 32'sh80000000; a_clip = 1'b1;
    end else begin
      a_sat = a_acc[31:0]; a_clip = 1'b0;
    end
    if (acc > 52'sd2147483647) begin
      f_sat = 32'sh7fffffff; f_clip = 1'b1;
    end else if (acc < -52'sd2147483648) begin
      f_sat = 32'sh80000000; f_clip = 1'b1;
    end else begin
      f_sat = acc[31:0]; f_clip = 1'b0;
    end
  end

  assign cmd_ready = (state == S_IDLE) && !out_valid;

  // each multiply step: phase 0 issues addresses, phase 1 latches operands, phase 2 accumulates
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      phase <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready && cmd.is_query) begin
            cur <= cmd;
            if (cmd.oor) begin
              out_data <= '{coord_value: '0, saturated: 1'b0, out_of_range: 1'b1};
              out_valid <= 1'b1;
            end else begin
              k <= '0; m <= '0; phase <= '0;
              acc <= '0; clip <= 1'b0;
              state <= S_AINIT;
            end
          end
        end
        S_AINIT: begin
          if (phase == 3'd1) begin
            a_acc <= 52'(ra_vc);
            phase <= '0; m <= '0;
            state <= S_AMUL;
          end else begin
            phase <= phase + 3'd1;
          end
        end
        S_AMUL: begin
          if (phase == 3'd2) begin
            a_acc <= a_acc - 52'(qprod);
            phase <= '0;
            if (m == 3'd5) state <= S_CMUL;
            else m <= m + 3'd1;
          end else begin
            if (phase == 3'd1) begin
              opa <= ra_vbm; opb <= ra_cn;
            end
            phase <= phase + 3'd1;
          end
        end
        S_CMUL: begin
          if (phase == 3'd2) begin
            acc <= acc + 52'(qprod);
            phase <= '0;
            state <= S_UMUL;
          end else begin
            if (phase == 3'd0) begin
              ak <= a_sat;
              if (a_clip) clip <= 1'b1;
            end else begin
              opa <= ra_uc; opb <= ra_vb;
            end
            phase <= phase + 3'd1;
          end
        end
        S_UMUL: begin
          if (phase == 3'd2) begin
            acc <= acc + 52'(qprod);
            phase <= '0;
            if (k == 3'd5) state <= S_DONE;
            else begin
              k <= k + 3'd1;
              state <= S_AINIT;
            end
          end else begin
            if (phase == 3'd1) begin
              opa <= ak; opb <= ra_ub;
            end
            phase <= phase + 3'd1;
          end
        end
        S_DONE: begin
          out_data <= '{coord_value: f_sat, saturated: clip | f_clip, out_of_range: 1'b0};
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
